[hdl/atifp_pkg.sv]
// shared types, character codes and defaults for the ascii two-number frame parser
package atifp_pkg;

  localparam int BUFFER_BYTES_DEF = 32;
  localparam int ACC_W            = 16;
  localparam int VAL_W            = 16;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [ACC_W-1:0] ACC_CAP = 16'd32768;
  localparam logic [VAL_W-1:0] POS_MAX = 16'd32767;

  typedef enum logic [7:0] {
    PH_WS1  = 8'b0000_0001,
    PH_SGN1 = 8'b0000_0010,
    PH_DIG1 = 8'b0000_0100,
    PH_WS2  = 8'b0000_1000,
    PH_SGN2 = 8'b0001_0000,
    PH_DIG2 = 8'b0010_0000,
    PH_DONE = 8'b0100_0000,
    PH_FAIL = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic                    valid;
    logic                    frame_ok;
    logic signed [VAL_W-1:0] deviation_value;
    logic signed [VAL_W-1:0] mode_value;
  } result_t;

  typedef struct packed {
    logic                    in_frame;
    logic signed [VAL_W-1:0] held_deviation;
    logic signed [VAL_W-1:0] held_mode;
  } status_t;

endpackage

[hdl/atifp_if.sv]
// valid/ready channel interfaces for received bytes and frame results
interface atifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface atifp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  frame_ok;
  logic signed [atifp_pkg::VAL_W-1:0]    deviation_value;
  logic signed [atifp_pkg::VAL_W-1:0]    mode_value;

  modport source (output valid, output frame_ok, output deviation_value,
                  output mode_value, input ready);
  modport sink (input valid, input frame_ok, input deviation_value,
                input mode_value, output ready);
endinterface

[hdl/atifp_in_stage.sv]
// input register holding one received byte
module atifp_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  atifp_in_if.sink         in_ch,
  input  logic             advance,
  output logic             s1_valid,
  output logic [7:0]       s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       in_fire;

  assign in_ch.ready = !valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_ch.rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

[hdl/atifp_parser.sv]
// incremental frame parser state and per-beat update logic
module atifp_parser #(
  parameter int BUFFER_BYTES = atifp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           c,
  output atifp_pkg::result_t   res,
  output atifp_pkg::status_t   stat
);

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 1);

  logic                                in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  atifp_pkg::phase_t                   phase_r, phase_nxt;
  logic [atifp_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                                neg_r, neg_nxt;
  logic [atifp_pkg::VAL_W-1:0]         first_r, first_nxt;
  logic [atifp_pkg::VAL_W-1:0]         held_dev_r, held_dev_nxt;
  logic [atifp_pkg::VAL_W-1:0]         held_mode_r, held_mode_nxt;

  logic                                is_ws, is_dig, is_sign;
  logic [19:0]                         acc_sum;
  logic [atifp_pkg::ACC_W-1:0]         acc_add;
  logic [atifp_pkg::VAL_W-1:0]         cur_val;
  logic                                ok;

  assign is_ws   = (c == atifp_pkg::CH_SPACE) ||
                   (c >= atifp_pkg::CH_TAB && c <= atifp_pkg::CH_CR);
  assign is_dig  = (c >= atifp_pkg::CH_ZERO) && (c <= atifp_pkg::CH_NINE);
  assign is_sign = (c == atifp_pkg::CH_PLUS) || (c == atifp_pkg::CH_MINUS);

  // times ten as two shifts, then cap
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};
  assign acc_add = (acc_sum > {4'd0, atifp_pkg::ACC_CAP}) ? atifp_pkg::ACC_CAP
                                                          : acc_sum[15:0];

  assign cur_val = neg_r ? (16'd0 - acc_r)
                         : ((acc_r > atifp_pkg::POS_MAX) ? atifp_pkg::POS_MAX : acc_r);

  assign ok = (phase_r == atifp_pkg::PH_DIG2) || (phase_r == atifp_pkg::PH_DONE);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    held_dev_nxt  = held_dev_r;
    held_mode_nxt = held_mode_r;
    res           = '0;

    if (fire) begin
      if (c == atifp_pkg::CH_HASH) begin
        in_frame_nxt = 1'b1;
        count_nxt    = CNT_W'(1);
        phase_nxt    = atifp_pkg::PH_WS1;
        acc_nxt      = '0;
        neg_nxt      = 1'b0;
        first_nxt    = '0;
      end else if (!in_frame_r) begin
        count_nxt = '0;
      end else if (c == atifp_pkg::CH_BANG) begin
        if (count_r < LIMIT) begin
          if (ok) begin
            held_dev_nxt  = first_r;
            held_mode_nxt = cur_val;
          end
          res.valid           = 1'b1;
          res.frame_ok        = ok;
          res.deviation_value = ok ? first_r : held_dev_r;
          res.mode_value      = ok ? cur_val : held_mode_r;
        end
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        phase_nxt    = atifp_pkg::PH_WS1;
        acc_nxt      = '0;
        neg_nxt      = 1'b0;
        first_nxt    = '0;
      end else if (count_r < LIMIT) begin
        count_nxt = count_r + CNT_W'(1);
        if (c == atifp_pkg::CH_NUL) begin
          if (phase_r == atifp_pkg::PH_DIG2) begin
            phase_nxt = atifp_pkg::PH_DONE;
          end else if (phase_r != atifp_pkg::PH_DONE) begin
            phase_nxt = atifp_pkg::PH_FAIL;
          end
        end else begin
          case (phase_r)
            atifp_pkg::PH_WS1, atifp_pkg::PH_WS2: begin
              if (is_sign) begin
                neg_nxt   = (c == atifp_pkg::CH_MINUS);
                phase_nxt = (phase_r == atifp_pkg::PH_WS1) ? atifp_pkg::PH_SGN1
                                                           : atifp_pkg::PH_SGN2;
              end else if (is_dig) begin
                acc_nxt   = acc_add;
                phase_nxt = (phase_r == atifp_pkg::PH_WS1) ? atifp_pkg::PH_DIG1
                                                           : atifp_pkg::PH_DIG2;
              end else if (!is_ws) begin
                phase_nxt = atifp_pkg::PH_FAIL;
              end
            end
            atifp_pkg::PH_SGN1, atifp_pkg::PH_SGN2: begin
              if (is_dig) begin
                acc_nxt   = acc_add;
                phase_nxt = (phase_r == atifp_pkg::PH_SGN1) ? atifp_pkg::PH_DIG1
                                                            : atifp_pkg::PH_DIG2;
              end else begin
                phase_nxt = atifp_pkg::PH_FAIL;
              end
            end
            atifp_pkg::PH_DIG1: begin
              if (is_dig) begin
                acc_nxt = acc_add;
              end else if (c == atifp_pkg::CH_COMMA) begin
                first_nxt = cur_val;
                acc_nxt   = '0;
                neg_nxt   = 1'b0;
                phase_nxt = atifp_pkg::PH_WS2;
              end else begin
                phase_nxt = atifp_pkg::PH_FAIL;
              end
            end
            atifp_pkg::PH_DIG2: begin
              if (is_dig) begin
                acc_nxt = acc_add;
              end else begin
                phase_nxt = atifp_pkg::PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        // frame overflow, dropped
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        phase_nxt    = atifp_pkg::PH_WS1;
        acc_nxt      = '0;
        neg_nxt      = 1'b0;
        first_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      count_r     <= '0;
      phase_r     <= atifp_pkg::PH_WS1;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      first_r     <= '0;
      held_dev_r  <= '0;
      held_mode_r <= '0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      first_r     <= first_nxt;
      held_dev_r  <= held_dev_nxt;
      held_mode_r <= held_mode_nxt;
    end
  end

  assign stat.in_frame       = in_frame_r;
  assign stat.held_deviation = held_dev_r;
  assign stat.held_mode      = held_mode_r;

endmodule

[hdl/atifp_out_stage.sv]
// result register driving the output channel
module atifp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  atifp_pkg::result_t res,
  output logic               advance,
  atifp_out_if.source        out_ch
);

  logic               valid_r, valid_nxt;
  atifp_pkg::result_t data_r, data_nxt;

  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (advance) begin
      valid_nxt = res.valid;
      data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.frame_ok        = data_r.frame_ok;
  assign out_ch.deviation_value = data_r.deviation_value;
  assign out_ch.mode_value      = data_r.mode_value;

endmodule

[hdl/ascii_two_int_frame_parser_top.sv]
// top level of the ascii two-number frame parser
// a closing '!' beat's result passes through the input register and then the result register
// throughput: one byte per cycle while the output channel is ready, with the parser update
// combinational between the input register and the result register
// reset: synchronous active-low rst_n clears the valid flags of both stages,
// the open frame and the held values to zero and returns the parser phase to PH_WS1
module ascii_two_int_frame_parser_top #(
  parameter int BUFFER_BYTES = atifp_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  atifp_in_if.sink    in_ch,
  atifp_out_if.source out_ch
);

  logic               advance;
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_fire;
  atifp_pkg::result_t res;
  atifp_pkg::status_t stat;

  assign s1_fire = s1_valid && advance;

  atifp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  atifp_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .c     (s1_byte),
    .res   (res),
    .stat  (stat)
  );

  atifp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

  // a stalled byte stays put in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_byte)))
    else $error("input register changed while stalled");

  // a failed frame reports the unchanged held values
  a_fail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.frame_ok) |->
      (res.deviation_value == stat.held_deviation && res.mode_value == stat.held_mode))
    else $error("failed frame altered reported values");

  // a result only comes from an open frame
  a_res_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (stat.in_frame && s1_fire))
    else $error("result outside an open frame");

  // a successful frame's values are the ones held afterwards
  a_ok_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.frame_ok) |=>
      (stat.held_deviation == $past(res.deviation_value) &&
       stat.held_mode == $past(res.mode_value)))
    else $error("held values not updated by successful frame");

endmodule
